>>> rtl/obst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obst_pkg
// Shared types, widths and codes of the optimal BST cost block.
// ----------------------------------------------------------------------------
package obst_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int WEIGHT_W     = 8;
    localparam int RANGE_W      = 7;
    localparam int COST_W       = 20;
    localparam int ROOT_OUT_W   = 7;
    localparam int TOTAL_W      = 14;
    localparam int COST_MAX     = 1048575;
    localparam int TOTAL_MAX    = 16383;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_QUERY   = 1'b1;
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_LOAD,
        CELL_LOAD_NEXT
    } cell_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_START,
        ST_ROOT,
        ST_BOUND,
        ST_CAND,
        ST_DRAIN,
        ST_WRITE,
        ST_QADDR,
        ST_QDATA,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

>>> rtl/optimal_bst_cost_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// optimal_bst_cost_dp
// Optimal binary search tree cost and root tables, Knuth bounded-root DP.
// ----------------------------------------------------------------------------
// A load word (op=0) appends one key weight unless MAX_KEYS keys are held;
// the running prefix sums shift into a row of cells. The load with last=1
// fills the tables: the row first rotates into place, then every range is
// solved in key-length order, through ROOT and WRITE for single keys and
// through ROOT, BOUND, CAND, DRAIN and WRITE for a longer range, with m
// candidate roots between the Knuth bounds; one candidate per cycle goes
// through the two cost table read ports. Over all ranges m sums to about n^2.
// After the fill the answer word is read out. A query word is answered
// through the table read port. Table entries are only read once written.
// ----------------------------------------------------------------------------
module optimal_bst_cost_dp
    import obst_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  op,
    input  wire logic [WEIGHT_W-1:0]   weight,
    input  wire logic                  last,
    input  wire logic [RANGE_W-1:0]    range_start,
    input  wire logic [RANGE_W-1:0]    range_end,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       kind,
    output logic      [COST_W-1:0]     cost,
    output logic      [ROOT_OUT_W-1:0] root,
    output logic      [TOTAL_W-1:0]    total_weight,
    output logic                       valid_res
);

    localparam int SIDE = MAX_KEYS + 1;
    localparam int KW   = $clog2(MAX_KEYS + 1);
    localparam int PW   = $clog2(MAX_KEYS * 255 + 1);
    localparam int AW   = $clog2(SIDE * SIDE);
    localparam int XW   = (KW > RANGE_W) ? KW : RANGE_W;

    function automatic logic [AW-1:0] tbl_addr(input logic [KW-1:0] a,
                                               input logic [KW-1:0] b);
        return AW'(a) * AW'(SIDE) + AW'(b);
    endfunction

    state_t state_reg, state_next;

    logic [KW-1:0]     key_count_reg;
    logic [PW-1:0]     acc_reg;
    logic              tables_ready_reg;
    logic              ok_reg;
    logic [KW-1:0]     cnt_reg;
    logic [KW-1:0]     h_reg, i_reg, j_reg, k_reg, lo_reg, hi_reg;
    logic [COST_W:0]   best_reg;
    logic [KW-1:0]     bk_reg;
    logic              cand_v_reg, cand_first_reg, cand_lz_reg, cand_rz_reg;
    logic [KW-1:0]     cand_k_reg;
    logic [KW-1:0]     q_i_reg, q_j_reg;
    logic              q_kind_reg, q_bad_reg;
    logic              res_kind_reg, res_valid_reg;
    logic [COST_W-1:0] res_cost_reg;
    logic [ROOT_OUT_W-1:0] res_root_reg;
    logic [TOTAL_W-1:0] res_total_reg;
    logic              out_valid_reg;

    logic [PW-1:0] p_q [SIDE];
    logic [PW-1:0] s_q [SIDE];
    logic [PW-1:0] wi_q [SIDE];
    logic [PW-1:0] wj_q [SIDE];
    logic [PW-1:0] pz [SIDE];
    logic [PW-1:0] wj_par [SIDE];
    cell_mode_t    p_mode, s_mode, wi_mode, wj_mode;
    logic [PW-1:0] p_tail;

    logic              in_acc, out_free, ovf, diag_end, fill_done;
    logic [KW-1:0]     kc_eff, kc_new;
    logic [PW-1:0]     acc_eff, acc_sum;
    logic              tbl_we;
    logic [AW-1:0]     cost_addr_a, cost_addr_b, root_addr_a, root_addr_b;
    logic [COST_W-1:0] cost_rd_a, cost_rd_b;
    logic [KW-1:0]     root_rd_a, root_rd_b;
    logic [KW-1:0]     lo_c, hi_c, hi_t;
    logic [COST_W:0]   cand_sum;
    logic [PW-1:0]     wdiff;
    logic [COST_W+1:0] wsum;
    logic [COST_W-1:0] cost_wd;
    logic [TOTAL_W-1:0] total_sat;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign kc_eff   = tables_ready_reg ? '0 : key_count_reg;
    assign acc_eff  = tables_ready_reg ? '0 : acc_reg;
    assign ovf      = (kc_eff == KW'(MAX_KEYS));
    assign acc_sum  = acc_eff + PW'(weight);
    assign kc_new   = ovf ? kc_eff : kc_eff + KW'(1);
    assign diag_end = (j_reg == key_count_reg);
    assign fill_done = diag_end && (h_reg == key_count_reg);
    assign total_sat = (32'(acc_reg) > 32'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX)
                                                       : TOTAL_W'(acc_reg);

    always_comb
    begin
        for (int c = 0; c < SIDE; c++)
        begin
            pz[c]     = (c == 0) ? '0 : p_q[c];
            wj_par[c] = (state_reg == ST_START) ? pz[c] : s_q[c];
        end
    end

    obst_ring #(.W(PW), .N(SIDE)) u_p_ring (
        .clk(clk), .rst_n(rst_n), .mode(p_mode), .tail_d(p_tail), .par_d(pz), .q(p_q)
    );
    obst_ring #(.W(PW), .N(SIDE)) u_s_ring (
        .clk(clk), .rst_n(rst_n), .mode(s_mode), .tail_d(s_q[0]), .par_d(pz), .q(s_q)
    );
    obst_ring #(.W(PW), .N(SIDE)) u_wi_ring (
        .clk(clk), .rst_n(rst_n), .mode(wi_mode), .tail_d(wi_q[0]), .par_d(pz), .q(wi_q)
    );
    obst_ring #(.W(PW), .N(SIDE)) u_wj_ring (
        .clk(clk), .rst_n(rst_n), .mode(wj_mode), .tail_d(wj_q[0]), .par_d(wj_par),
        .q(wj_q)
    );

    obst_tables #(.MAX_KEYS(MAX_KEYS)) u_tables (
        .clk         (clk),
        .we          (tbl_we),
        .waddr       (tbl_addr(i_reg, j_reg)),
        .cost_wd     (cost_wd),
        .root_wd     (bk_reg),
        .cost_addr_a (cost_addr_a),
        .cost_addr_b (cost_addr_b),
        .root_addr_a (root_addr_a),
        .root_addr_b (root_addr_b),
        .cost_rd_a   (cost_rd_a),
        .cost_rd_b   (cost_rd_b),
        .root_rd_a   (root_rd_a),
        .root_rd_b   (root_rd_b)
    );

    // Knuth bounds, clamped to the range
    always_comb
    begin
        lo_c = (root_rd_a < i_reg + KW'(1)) ? i_reg + KW'(1) : root_rd_a;
        hi_t = (root_rd_b > j_reg) ? j_reg : root_rd_b;
        hi_c = (hi_t < lo_c) ? lo_c : hi_t;
    end

    assign cand_sum = (cand_lz_reg ? (COST_W+1)'(0) : (COST_W+1)'(cost_rd_a))
                    + (cand_rz_reg ? (COST_W+1)'(0) : (COST_W+1)'(cost_rd_b));
    assign wdiff    = wj_q[0] - wi_q[0];
    assign wsum     = (COST_W+2)'(best_reg) + (COST_W+2)'(wdiff);
    // never reached for 8-bit weights; kept as a hard ceiling
    assign cost_wd  = (32'(wsum) > 32'(COST_MAX)) ? COST_W'(COST_MAX) : COST_W'(wsum);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (op == OP_QUERY)
                    begin
                        state_next = ST_QADDR;
                    end
                    else if (last)
                    begin
                        state_next = ST_ALIGN;
                    end
                    else if (ovf)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_ALIGN:  state_next = (cnt_reg == '0) ? ST_START : ST_ALIGN;
            ST_START:  state_next = ST_ROOT;
            ST_ROOT:   state_next = (h_reg == KW'(1)) ? ST_WRITE : ST_BOUND;
            ST_BOUND:  state_next = ST_CAND;
            ST_CAND:   state_next = (k_reg == hi_reg) ? ST_DRAIN : ST_CAND;
            ST_DRAIN:  state_next = ST_WRITE;
            ST_WRITE:  state_next = fill_done ? ST_QADDR : ST_ROOT;
            ST_QADDR:  state_next = ST_QDATA;
            ST_QDATA:  state_next = ST_EMIT;
            ST_EMIT:   state_next = out_free ? ST_IDLE : ST_EMIT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        p_mode   = CELL_HOLD;
        s_mode   = CELL_HOLD;
        wi_mode  = CELL_HOLD;
        wj_mode  = CELL_HOLD;
        p_tail   = acc_sum;
        tbl_we   = 1'b0;
        cost_addr_a = tbl_addr(i_reg, k_reg - KW'(1));
        cost_addr_b = tbl_addr(k_reg, j_reg);
        root_addr_a = tbl_addr(i_reg, j_reg - KW'(1));
        root_addr_b = tbl_addr(i_reg + KW'(1), j_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (op == OP_LOAD) && !ovf)
                begin
                    p_mode = CELL_SHIFT;
                end
            end
            ST_ALIGN:
            begin
                p_tail = p_q[0];
                if (cnt_reg != '0)
                begin
                    p_mode = CELL_SHIFT;
                end
            end
            ST_START:
            begin
                p_mode  = CELL_LOAD;
                wi_mode = CELL_LOAD;
                s_mode  = CELL_LOAD_NEXT;
                wj_mode = CELL_LOAD_NEXT;
            end
            ST_WRITE:
            begin
                tbl_we = 1'b1;
                if (!diag_end)
                begin
                    wi_mode = CELL_SHIFT;
                    wj_mode = CELL_SHIFT;
                end
                else if (!fill_done)
                begin
                    wi_mode = CELL_LOAD;
                    s_mode  = CELL_SHIFT;
                    wj_mode = CELL_LOAD_NEXT;
                end
            end
            ST_QADDR:
            begin
                cost_addr_a = tbl_addr(q_i_reg, q_j_reg);
                root_addr_a = tbl_addr(q_i_reg, q_j_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            key_count_reg    <= '0;
            acc_reg          <= '0;
            tables_ready_reg <= 1'b0;
            ok_reg           <= 1'b0;
            cnt_reg          <= '0;
            cand_v_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cand_v_reg <= (state_reg == ST_CAND);
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && (op == OP_LOAD))
                    begin
                        tables_ready_reg <= 1'b0;
                        key_count_reg    <= kc_new;
                        acc_reg          <= ovf ? acc_eff : acc_sum;
                        ok_reg           <= !ovf;
                        cnt_reg          <= KW'(MAX_KEYS) - kc_new;
                    end
                end
                ST_WRITE:
                begin
                    if (fill_done)
                    begin
                        tables_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (state_reg == ST_ALIGN && cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - KW'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (cand_v_reg && (cand_first_reg || cand_sum < best_reg))
        begin
            best_reg <= cand_sum;
            bk_reg   <= cand_k_reg;
        end
        cand_k_reg     <= k_reg;
        cand_first_reg <= (k_reg == lo_reg);
        cand_lz_reg    <= (k_reg == i_reg + KW'(1));
        cand_rz_reg    <= (k_reg == j_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                q_kind_reg <= KIND_QUERY;
                q_i_reg    <= KW'(range_start);
                q_j_reg    <= KW'(range_end);
                q_bad_reg  <= !tables_ready_reg || (range_start >= range_end)
                              || (XW'(range_end) > XW'(key_count_reg));
                res_kind_reg  <= KIND_LOAD;
                res_cost_reg  <= '0;
                res_root_reg  <= '0;
                res_valid_reg <= 1'b0;
                res_total_reg <= (32'(acc_eff) > 32'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX)
                                                                 : TOTAL_W'(acc_eff);
            end
            ST_START:
            begin
                h_reg <= KW'(1);
                i_reg <= '0;
                j_reg <= KW'(1);
            end
            ST_ROOT:
            begin
                best_reg <= '0;
                bk_reg   <= i_reg + KW'(1);
            end
            ST_BOUND:
            begin
                lo_reg <= lo_c;
                hi_reg <= hi_c;
                k_reg  <= lo_c;
            end
            ST_CAND:
            begin
                k_reg <= k_reg + KW'(1);
            end
            ST_WRITE:
            begin
                if (!diag_end)
                begin
                    i_reg <= i_reg + KW'(1);
                    j_reg <= j_reg + KW'(1);
                end
                else if (!fill_done)
                begin
                    h_reg <= h_reg + KW'(1);
                    i_reg <= '0;
                    j_reg <= h_reg + KW'(1);
                end
                q_kind_reg <= KIND_LOAD;
                q_i_reg    <= '0;
                q_j_reg    <= key_count_reg;
                q_bad_reg  <= 1'b0;
            end
            ST_QDATA:
            begin
                res_kind_reg <= q_kind_reg;
                if (q_bad_reg)
                begin
                    res_cost_reg  <= '0;
                    res_root_reg  <= '0;
                    res_total_reg <= '0;
                    res_valid_reg <= 1'b0;
                end
                else
                begin
                    res_cost_reg  <= cost_rd_a;
                    res_root_reg  <= ROOT_OUT_W'(root_rd_a);
                    res_total_reg <= total_sat;
                    res_valid_reg <= (q_kind_reg == KIND_QUERY) ? 1'b1 : ok_reg;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    kind         <= res_kind_reg;
                    cost         <= res_cost_reg;
                    root         <= res_root_reg;
                    total_weight <= res_total_reg;
                    valid_res    <= res_valid_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_ready_clear_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT || state_reg == ST_CAND) |-> !tables_ready_reg)
        else $error("tables marked ready during fill");

    a_cand_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CAND) |-> (k_reg >= lo_reg && k_reg <= hi_reg
                                    && k_reg > i_reg && k_reg <= j_reg))
        else $error("candidate root outside Knuth bounds");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> (i_reg < j_reg && j_reg <= key_count_reg))
        else $error("table write outside loaded range");

    a_emit_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && fill_done) |=> (state_reg == ST_QADDR && tables_ready_reg))
        else $error("fill end did not start the answer read");

endmodule
`default_nettype wire

>>> rtl/obst_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obst_cell
// One prefix-weight cell of a ring: hold, shift from neighbor, or load its own or the next cell's parallel input.
// ----------------------------------------------------------------------------
module obst_cell
    import obst_pkg::*;
#(
    parameter int W = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cell_mode_t   mode,
    input  wire logic [W-1:0] shift_d,
    input  wire logic [W-1:0] par_d,
    input  wire logic [W-1:0] par_next_d,
    output logic      [W-1:0] q
);

    logic [W-1:0] val_reg;
    logic [W-1:0] val_next;

    always_comb
    begin
        unique case (mode)
            CELL_HOLD:      val_next = val_reg;
            CELL_SHIFT:     val_next = shift_d;
            CELL_LOAD:      val_next = par_d;
            CELL_LOAD_NEXT: val_next = par_next_d;
            default:        val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else
        begin
            val_reg <= val_next;
        end
    end

    assign q = val_reg;

endmodule
`default_nettype wire

>>> rtl/obst_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obst_ring
// Row of cells; shift moves each cell toward cell 0, tail enters at the end.
// ----------------------------------------------------------------------------
module obst_ring
    import obst_pkg::*;
#(
    parameter int W = 8,
    parameter int N = 2
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cell_mode_t   mode,
    input  wire logic [W-1:0] tail_d,
    input  wire logic [W-1:0] par_d [N],
    output logic      [W-1:0] q     [N]
);

    genvar c;
    generate
        for (c = 0; c < N; c++)
        begin : g_cell
            logic [W-1:0] sh;
            logic [W-1:0] pn;
            if (c == N - 1)
            begin : g_end
                assign sh = tail_d;
                assign pn = par_d[0];
            end
            else
            begin : g_mid
                assign sh = q[c+1];
                assign pn = par_d[c+1];
            end
            obst_cell #(.W(W)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .mode       (mode),
                .shift_d    (sh),
                .par_d      (par_d[c]),
                .par_next_d (pn),
                .q          (q[c])
            );
        end
    endgenerate

endmodule
`default_nettype wire

>>> rtl/obst_tables.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obst_tables
// Cost and root tables, one write port and two registered read ports each.
// ----------------------------------------------------------------------------
module obst_tables
    import obst_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
)
(
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [$clog2((MAX_KEYS+1)*(MAX_KEYS+1))-1:0] waddr,
    input  wire logic [COST_W-1:0]                         cost_wd,
    input  wire logic [$clog2(MAX_KEYS+1)-1:0]             root_wd,
    input  wire logic [$clog2((MAX_KEYS+1)*(MAX_KEYS+1))-1:0] cost_addr_a,
    input  wire logic [$clog2((MAX_KEYS+1)*(MAX_KEYS+1))-1:0] cost_addr_b,
    input  wire logic [$clog2((MAX_KEYS+1)*(MAX_KEYS+1))-1:0] root_addr_a,
    input  wire logic [$clog2((MAX_KEYS+1)*(MAX_KEYS+1))-1:0] root_addr_b,
    output logic      [COST_W-1:0]                         cost_rd_a,
    output logic      [COST_W-1:0]                         cost_rd_b,
    output logic      [$clog2(MAX_KEYS+1)-1:0]             root_rd_a,
    output logic      [$clog2(MAX_KEYS+1)-1:0]             root_rd_b
);

    localparam int SIDE  = MAX_KEYS + 1;
    localparam int DEPTH = SIDE * SIDE;
    localparam int KW    = $clog2(MAX_KEYS + 1);

    logic [COST_W-1:0] cost_mem [DEPTH];
    logic [KW-1:0]     root_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cost_mem[waddr] <= cost_wd;
            root_mem[waddr] <= root_wd;
        end
        cost_rd_a <= cost_mem[cost_addr_a];
        cost_rd_b <= cost_mem[cost_addr_b];
        root_rd_a <= root_mem[root_addr_a];
        root_rd_b <= root_mem[root_addr_b];
    end

endmodule
`default_nettype wire
